### hw/rtl/skbs_pkg.sv
`default_nettype none

package skbs_pkg;

    // fixed field widths
    localparam int INDEX_W = 8;
    localparam int KEY_IN_W = 32;
    localparam int POS_W = 8;
    localparam int COUNT_W = 8;

    // operation codes carried on s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic write;     // store key at wrapped slot
        logic load;      // capture search key and initial bounds
        logic probe;     // issue first table read
        logic step;      // compare read data, narrow bounds, issue next read
        logic out_load;  // move result into output register
    } skbs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;     // no entries to search
        logic more;      // another probe is needed
    } skbs_sts_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_key_binary_search_unit.sv
// a write is stored on accept; a search runs load, first probe, a compare per probe, finish
// p = probes = up to ceil(log2(count + 1)), at most 8, one key-table read per cycle
// one write per cycle while idle; a search holds s_tready low until its result is loaded
// the registered read port of the key-table ram paces the probe loop
// reset: synchronous active-low aresetn clears the controller, m_tvalid and key_count
// key table contents are not cleared and are undefined until written
`default_nettype none

module sorted_key_binary_search_unit
    import skbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // key_count register
    input  wire logic                          cfg_we,
    input  wire logic [COUNT_W-1:0]            cfg_wdata,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [INDEX_W+KEY_IN_W-1:0]   s_tdata,   // entry_index [7:0], key_value [39:8]
    input  wire logic                          s_tuser,   // operation [0]
    // result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [POS_W-1:0]              m_tdata,   // position [7:0]
    output logic                               m_tuser    // found [0]
);

    skbs_cmd_t cmd;
    skbs_sts_t sts;

    // controller: accepts items, sequences the probe loop, owns m_tvalid
    skbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: key table, search bounds, compare, output register
    skbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_slot   (s_tdata[INDEX_W-1:0]),
        .in_key    (s_tdata[INDEX_W+KEY_IN_W-1:INDEX_W]),
        .out_pos   (m_tdata),
        .out_found (m_tuser)
    );

endmodule

`default_nettype wire

### hw/rtl/skbs_ram.sv
`default_nettype none

module skbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/skbs_dp.sv
`default_nettype none

module skbs_dp
    import skbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire skbs_cmd_t           cmd,
    output skbs_sts_t                sts,
    input  wire logic                cfg_we,
    input  wire logic [COUNT_W-1:0]  cfg_wdata,
    input  wire logic [INDEX_W-1:0]  in_slot,
    input  wire logic [KEY_IN_W-1:0] in_key,
    output logic      [POS_W-1:0]    out_pos,
    output logic                     out_found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SAT = (TABLE_DEPTH < 255) ? TABLE_DEPTH : 255;
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(SAT);
    localparam int RW = 20;

    logic [COUNT_W-1:0]   count_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [POS_W-1:0]     left_reg;
    logic [POS_W-1:0]     hi_reg;     // exclusive upper bound
    logic [POS_W-1:0]     mid_reg;
    logic                 found_reg;
    logic [POS_W-1:0]     pos_out_reg;
    logic                 found_out_reg;

    logic [COUNT_W-1:0]   count_eff;
    logic [KEY_WIDTH-1:0] rdata;
    logic                 hit;
    logic                 below;
    logic [POS_W-1:0]     left_next;
    logic [POS_W-1:0]     hi_next;
    logic [POS_W-1:0]     mid_next;
    logic [AW-1:0]        waddr;

    // slot modulo depth by restoring subtraction of shifted depths
    function automatic logic [AW-1:0] wrap_slot(input logic [INDEX_W-1:0] slot);
        logic [RW-1:0] r;
        r = RW'(slot);
        for (int k = 6; k >= 0; k--) begin
            if (r >= (RW'(TABLE_DEPTH) << k)) begin
                r = r - (RW'(TABLE_DEPTH) << k);
            end
        end
        return AW'(r);
    endfunction

    function automatic logic [POS_W-1:0] midpoint(input logic [POS_W-1:0] lo,
                                                  input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] span;
        span = hi - lo - POS_W'(1);
        return lo + (span >> 1);
    endfunction

    assign count_eff = (count_reg > COUNT_MAX) ? COUNT_MAX : count_reg;
    assign waddr = wrap_slot(in_slot);

    skbs_ram #(
        .WIDTH(KEY_WIDTH),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.write),
        .waddr (waddr),
        .wdata (KEY_WIDTH'(in_key)),
        .re    ((cmd.probe && !sts.empty) || (cmd.step && sts.more)),
        .raddr (AW'(mid_next)),
        .rdata (rdata)
    );

    assign hit = (rdata == key_reg);
    assign below = (rdata < key_reg);

    always_comb begin
        left_next = left_reg;
        hi_next = hi_reg;
        if (cmd.step && !hit) begin
            if (below) begin
                left_next = mid_reg + POS_W'(1);
            end else begin
                hi_next = mid_reg;
            end
        end
        mid_next = midpoint(left_next, hi_next);
    end

    assign sts.empty = (left_reg >= hi_reg);
    assign sts.more = !hit && (left_next < hi_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= KEY_WIDTH'(in_key);
            left_reg <= '0;
            hi_reg <= count_eff;
            found_reg <= 1'b0;
        end else if (cmd.probe) begin
            mid_reg <= mid_next;
        end else if (cmd.step) begin
            if (hit) begin
                left_reg <= mid_reg;
                found_reg <= 1'b1;
            end else begin
                left_reg <= left_next;
                hi_reg <= hi_next;
                mid_reg <= mid_next;
            end
        end
        if (cmd.out_load) begin
            pos_out_reg <= left_reg;
            found_out_reg <= found_reg;
        end
    end

    assign out_pos = pos_out_reg;
    assign out_found = found_out_reg;

endmodule

`default_nettype wire

### hw/rtl/skbs_ctrl.sv
`default_nettype none

module skbs_ctrl
    import skbs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic      s_op,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output skbs_cmd_t      cmd,
    input  wire skbs_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_CMP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_SEARCH) begin
                        cmd.load = 1'b1;
                        state_next = ST_START;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_START: begin
                cmd.probe = 1'b1;
                state_next = sts.empty ? ST_FINISH : ST_CMP;
            end
            ST_CMP: begin
                cmd.step = 1'b1;
                state_next = sts.more ? ST_CMP : ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

### hw/rtl/skbs_checker.sv
`default_nettype none

module skbs_checker
    import skbs_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             s_tuser,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [POS_W-1:0] m_tdata,
    input wire logic             m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a write item leaves the block ready in the cycle after it is accepted
    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_WRITE) |=> s_tready)
        else $error("not ready after write item");

    // an accepted search item leaves the block not ready
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_SEARCH) |=> !s_tready)
        else $error("ready during search");

    // a new result only follows a busy cycle of the search
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without search");

endmodule

bind sorted_key_binary_search_unit skbs_checker u_skbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/sorted_key_binary_search_unit_test.sv
`timescale 1ns / 1ps

module sorted_key_binary_search_unit_test;
    import skbs_pkg::*;

    localparam int TABLE_SLOTS = 256;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 300;       // result side held off this many cycles once
    localparam int PHASES = 10;
    localparam int SEARCHES_PER_PHASE = 12;

    // one search answer as it leaves the block
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } search_result_t;

    // directed stimulus rows
    typedef enum logic [1:0] {ROW_WRITE, ROW_SEARCH, ROW_COUNT} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [INDEX_W-1:0]    value;      // slot for writes, key_count for count rows
        logic [KEY_IN_W-1:0]   key;
        logic                  typed;      // expected answer given in the row
        logic [POS_W-1:0]      exp_pos;
        logic                  exp_found;
    } directed_row_t;

    localparam int DIRECTED_LEN = 22;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // empty table right after reset
        '{ROW_SEARCH, 8'd0,   32'h0000_0000, 1'b1, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0},
        // small sorted table with the key extremes, plus the top slot
        '{ROW_WRITE,  8'd0,   32'h0000_0000, 1'b0, 8'd0, 1'b0},
        '{ROW_WRITE,  8'd1,   32'h0000_0100, 1'b0, 8'd0, 1'b0},
        '{ROW_WRITE,  8'd2,   32'h8000_0000, 1'b0, 8'd0, 1'b0},
        '{ROW_WRITE,  8'd3,   32'hFFFF_FFFF, 1'b0, 8'd0, 1'b0},
        '{ROW_WRITE,  8'd255, 32'hFFFF_FFFF, 1'b0, 8'd0, 1'b0},
        // single entry: hit at 0, or insert after it
        '{ROW_COUNT,  8'd1,   32'h0,         1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h0000_0000, 1'b1, 8'd0, 1'b1},
        '{ROW_SEARCH, 8'd0,   32'hFFFF_FFFF, 1'b1, 8'd1, 1'b0},
        // four entries: a hit on each one and misses between them
        '{ROW_COUNT,  8'd4,   32'h0,         1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h0000_0000, 1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'hFFFF_FFFF, 1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h0000_0100, 1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h8000_0000, 1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h0000_00FF, 1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h8000_0001, 1'b0, 8'd0, 1'b0},
        // break the ordering, the probes still decide
        '{ROW_WRITE,  8'd1,   32'h9000_0000, 1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h9000_0000, 1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h0000_0100, 1'b0, 8'd0, 1'b0},
        // back to an empty table
        '{ROW_COUNT,  8'd0,   32'h0,         1'b0, 8'd0, 1'b0},
        '{ROW_SEARCH, 8'd0,   32'h1234_5678, 1'b1, 8'd0, 1'b0}
    };

    // dut ports
    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [COUNT_W-1:0]          cfg_wdata = '0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [INDEX_W+KEY_IN_W-1:0] s_tdata = '0;   // entry_index [7:0], key_value [39:8]
    logic                        s_tuser = 1'b0;  // operation [0]
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [POS_W-1:0]            m_tdata;         // position [7:0]
    logic                        m_tuser;         // found [0]

    // mirror of the block state, updated as items are accepted and key_count is written
    logic [KEY_IN_W-1:0] key_mirror [TABLE_SLOTS];
    logic [COUNT_W-1:0]  count_mirror = '0;

    // answers still owed by the block, oldest first
    search_result_t pending_results [$];
    int mismatches = 0;

    // idle controls for the stimulus and the result side
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;
    bit hold_request = 1'b0;

    sorted_key_binary_search_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // binary search over the first count_mirror slots, insertion point on a miss
    function automatic search_result_t lower_bound_search(logic [KEY_IN_W-1:0] key);
        int lo;
        int hi;
        int mid;
        search_result_t res;
        lo = 0;
        hi = int'(count_mirror) - 1;
        res.found = 1'b0;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_mirror[mid] == key) begin
                res.position = POS_W'(mid);
                res.found = 1'b1;
                return res;
            end else if (key_mirror[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        res.position = POS_W'(lo);
        return res;
    endfunction

    // idle stretch: mostly short, now and then long
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // search keys lean toward stored keys and their neighbors
    function automatic logic [KEY_IN_W-1:0] pick_search_key();
        int sel;
        int slot;
        sel = $urandom_range(0, 99);
        slot = (count_mirror == 0) ? 0 : $urandom_range(0, int'(count_mirror) - 1);
        if (count_mirror == 0 || sel >= 85)
            return $urandom();
        if (sel < 45)
            return key_mirror[slot];
        if (sel < 65)
            return key_mirror[slot] + 1'b1;
        if (sel < 80)
            return key_mirror[slot] - 1'b1;
        return (sel % 2 == 0) ? '0 : '1;
    endfunction

    // offer one item, wait for its handshake, then record what it owes
    task automatic send_item(input logic op, input logic [INDEX_W-1:0] slot,
                             input logic [KEY_IN_W-1:0] key, input logic typed,
                             input search_result_t typed_result);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 99) < 50) ? idle_length() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {key, slot};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_WRITE)
            key_mirror[slot] = key;
        else
            pending_results.push_back(typed ? typed_result : lower_bound_search(key));
    endtask

    // stop offering and let every owed answer come out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // key_count only changes while the block is idle
    task automatic set_key_count(input logic [COUNT_W-1:0] count);
        drain_results();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(negedge aclk);
        cfg_we <= 1'b0;
        count_mirror = count;
    endtask

    // rewrite one slot, normally keeping the table in order
    task automatic send_key_update();
        int slot;
        logic [KEY_IN_W-1:0] lo;
        logic [KEY_IN_W-1:0] hi;
        logic [KEY_IN_W-1:0] value;
        longint unsigned span;
        slot = $urandom_range(0, TABLE_SLOTS - 1);
        lo = (slot == 0) ? '0 : key_mirror[slot - 1];
        hi = (slot == TABLE_SLOTS - 1) ? '1 : key_mirror[slot + 1];
        if ($urandom_range(0, 99) < 15) begin
            value = $urandom();    // noise, may leave the table unsorted
        end else if (lo <= hi) begin
            span = longint'(hi) - longint'(lo) + 1;
            value = lo + KEY_IN_W'(longint'($urandom()) % span);
        end else begin
            value = lo;
        end
        send_item(OP_WRITE, INDEX_W'(slot), value, 1'b0, '0);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && rx_stalls && $urandom_range(0, 99) < 25) begin
                stall_left = idle_length();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each delivered answer with the oldest one owed
    initial begin
        search_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none owed, position %0d found %0b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.position) begin
                        mismatches++;
                        $display("%0t: position expected %0d got %0d",
                                 $time, want.position, m_tdata);
                    end
                    if (m_tuser !== want.found) begin
                        mismatches++;
                        $display("%0t: found expected %0b got %0b",
                                 $time, want.found, m_tuser);
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        directed_row_t row;
        logic [KEY_IN_W-1:0] next_key;
        logic [COUNT_W-1:0] phase_counts [PHASES];
        int p;
        int n;

        phase_counts = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd0, 8'd128, 8'd0, 8'd3, 8'd0, 8'd255};
        phase_counts[4] = COUNT_W'($urandom_range(4, 254));
        phase_counts[6] = COUNT_W'($urandom_range(4, 254));
        phase_counts[8] = COUNT_W'($urandom_range(4, 254));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            row = DIRECTED_ROWS[i];
            case (row.kind)
                ROW_COUNT:  set_key_count(row.value);
                ROW_WRITE:  send_item(OP_WRITE, row.value, row.key, 1'b0, '0);
                default:    send_item(OP_SEARCH, INDEX_W'($urandom()), row.key, row.typed,
                                      {row.exp_pos, row.exp_found});
            endcase
        end

        // fill every slot with ascending keys, duplicates now and then
        next_key = $urandom_range(0, 1000);
        for (int slot = 0; slot < TABLE_SLOTS; slot++) begin
            send_item(OP_WRITE, INDEX_W'(slot), next_key, 1'b0, '0);
            if ($urandom_range(0, 15) != 0)
                next_key = next_key + $urandom_range(1, 24'hFF_FFFF);
        end

        // search phases over several table sizes
        for (p = 0; p < PHASES; p++) begin
            tx_gaps = (p % 3 != 0);
            rx_stalls = (p % 4 != 2);
            set_key_count(phase_counts[p]);
            // hold the result side off while items keep coming
            if (p == 0)
                hold_request = 1'b1;
            for (n = 0; n < SEARCHES_PER_PHASE; n++) begin
                // sender waits for every answer once mid phase
                if (p == 4 && n == SEARCHES_PER_PHASE / 2)
                    drain_results();
                if ($urandom_range(0, 99) < 10)
                    send_key_update();
                send_item(OP_SEARCH, INDEX_W'($urandom()), pick_search_key(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("sorted_key_binary_search_unit_test: clean");
        else
            $display("sorted_key_binary_search_unit_test: errors");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("sorted_key_binary_search_unit_test: errors");
        $finish;
    end

endmodule
